// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/cbba_pkg.sv
// Shared types, widths and codes for the contiguous block bitmap allocator.
package cbba_pkg;

  localparam int POINTS_W = 10;
  localparam int FIRST_W  = 5;
  localparam int COUNT_W  = 6;
  localparam int MAP_W    = 32;
  // holds a run length up to 64 and first + count up to 94
  localparam int SPAN_W   = 7;

  localparam int NUM_BLOCKS_DEF  = 32;
  localparam int BLOCK_VERTS_DEF = 64;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [POINTS_W-1:0] request_points;
    logic [FIRST_W-1:0]  free_first_block;
    logic [COUNT_W-1:0]  free_block_count;
  } cbba_req_t;

  typedef struct packed {
    logic               ok;
    logic [FIRST_W-1:0] first_block;
    logic [COUNT_W-1:0] block_count;
    logic [MAP_W-1:0]   used_map;
  } cbba_rsp_t;

  typedef struct packed {
    logic               load;
    logic               shift;
    logic               commit;
    logic               clear;
    logic [SPAN_W-1:0]  span;
    logic [FIRST_W-1:0] lo;
    logic [SPAN_W-1:0]  hi;
  } cbba_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIZE,
    ST_LOAD,
    ST_SCAN,
    ST_FREE
  } cbba_state_t;

endpackage

// File: rtl/cbba_cell.sv
// One block of the map: usage bit, scan bit, window bit and grant bit.
module cbba_cell
  import cbba_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  cbba_ctl_t ctl,
  input  logic      scan_in,
  output logic      scan_out,
  input  logic      grant_in,
  output logic      grant_out,
  output logic      used,
  output logic      conflict
);

  localparam logic [SPAN_W-1:0] IdxS = SPAN_W'(IDX);

  logic u;
  logic s;
  logic m;
  logic g;
  logic in_window;
  logic in_clear;

  assign in_window = IdxS < ctl.span;
  assign in_clear  = (IdxS >= SPAN_W'(ctl.lo)) && (IdxS < ctl.hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      u <= 1'b0;
    end else if (ctl.clear && in_clear) begin
      u <= 1'b0;
    end else if (ctl.commit && g) begin
      u <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      s <= u;
      m <= in_window;
      g <= in_window;
    end else if (ctl.shift) begin
      s <= scan_in;
      g <= grant_in;
    end
  end

  assign scan_out  = s;
  assign grant_out = g;
  assign used      = u;
  assign conflict  = s & m;

endmodule

// File: rtl/contiguous_block_bitmap_allocator_top.sv
// Free: the FREE state clears the range, then the strobe. Allocate: one sizing multiply,
// a load state, then one candidate position per cycle through the cell chain;
// the strobe follows the scan step that grants b, b = granted first block (failure after at
// most NUM_BLOCKS-blocks+1 scan steps, oversize failure straight from the load state).
// A new start is taken in the strobe cycle. Synchronous reset clears the map.
module contiguous_block_bitmap_allocator_top
  import cbba_pkg::*;
#(
  parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int BLOCK_VERTS = BLOCK_VERTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  cbba_req_t req,
  output logic      done,
  output cbba_rsp_t rsp
);

  localparam int P    = BLOCK_VERTS / 2;
  localparam int XW   = $clog2(1024 + P + 1);
  localparam int SH   = XW + $clog2(P);
  localparam int RW   = SH + 1;
  localparam longint RECIP = ((64'd1 << SH) + P - 1) / P;
  localparam int PW   = XW + RW;
  localparam int BFW  = PW - SH;
  localparam int BIW  = $clog2(NUM_BLOCKS);
  localparam int MAPN = (NUM_BLOCKS < MAP_W) ? NUM_BLOCKS : MAP_W;

  cbba_state_t state, state_next;
  cbba_ctl_t   ctl;

  logic [XW-1:0]      x_r;
  logic [PW-1:0]      prod_r;
  logic [SPAN_W-1:0]  blk_r;
  logic [BIW-1:0]     b;
  logic [FIRST_W-1:0] lo_r;
  logic [SPAN_W-1:0]  hi_r;
  logic               ok_r;
  logic [FIRST_W-1:0] first_r;
  logic [COUNT_W-1:0] count_r;

  logic [BFW-1:0]        blocks_full;
  logic                  too_big;
  logic                  accept;
  logic                  any_conflict;
  logic                  last;
  logic [NUM_BLOCKS-1:0] s_v;
  logic [NUM_BLOCKS-1:0] g_v;
  logic [NUM_BLOCKS-1:0] u_v;
  logic [NUM_BLOCKS-1:0] c_v;

  assign busy         = state != ST_IDLE;
  assign accept       = start && !busy;
  assign blocks_full  = prod_r[PW-1:SH];
  assign too_big      = blocks_full > BFW'(NUM_BLOCKS);
  assign any_conflict = |c_v;
  assign last = (SPAN_W'(b) + blk_r) >= SPAN_W'(NUM_BLOCKS);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req.opcode == OP_FREE) ? ST_FREE : ST_SIZE;
        end
      end
      ST_SIZE: state_next = ST_LOAD;
      ST_LOAD: state_next = too_big ? ST_IDLE : ST_SCAN;
      ST_SCAN: begin
        if (!any_conflict || last) begin
          state_next = ST_IDLE;
        end
      end
      ST_FREE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.load   = 1'b0;
    ctl.shift  = 1'b0;
    ctl.commit = 1'b0;
    ctl.clear  = 1'b0;
    ctl.span   = SPAN_W'(blocks_full);
    ctl.lo     = lo_r;
    ctl.hi     = hi_r;
    case (state)
      ST_LOAD: ctl.load = !too_big;
      ST_SCAN: begin
        ctl.commit = !any_conflict;
        ctl.shift  = any_conflict && !last;
      end
      ST_FREE: ctl.clear = 1'b1;
      default: ctl.load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == ST_LOAD) && too_big) ||
               ((state == ST_SCAN) && (!any_conflict || last)) ||
               (state == ST_FREE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r  <= XW'(req.request_points) + XW'(P + 1);
      lo_r <= req.free_first_block;
      hi_r <= SPAN_W'(req.free_first_block) + SPAN_W'(req.free_block_count);
    end
    if (state == ST_SIZE) begin
      prod_r <= PW'(x_r) * PW'(RECIP);
    end
    case (state)
      ST_LOAD: begin
        blk_r   <= SPAN_W'(blocks_full);
        b       <= '0;
        ok_r    <= 1'b0;
        first_r <= '0;
        count_r <= '0;
      end
      ST_SCAN: begin
        if (!any_conflict) begin
          ok_r    <= 1'b1;
          first_r <= FIRST_W'(b);
          count_r <= COUNT_W'(blk_r);
        end else begin
          b <= b + BIW'(1);
        end
      end
      ST_FREE: begin
        ok_r    <= 1'b1;
        first_r <= '0;
        count_r <= '0;
      end
      default: ok_r <= ok_r;
    endcase
  end

  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    logic scan_in;
    logic grant_in;
    if (i == NUM_BLOCKS - 1) begin : g_top
      assign scan_in = 1'b1;
    end else begin : g_mid
      assign scan_in = s_v[i+1];
    end
    if (i == 0) begin : g_bot
      assign grant_in = 1'b0;
    end else begin : g_up
      assign grant_in = g_v[i-1];
    end
    cbba_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .scan_in  (scan_in),
      .scan_out (s_v[i]),
      .grant_in (grant_in),
      .grant_out(g_v[i]),
      .used     (u_v[i]),
      .conflict (c_v[i])
    );
  end

  assign rsp.ok          = ok_r;
  assign rsp.first_block = first_r;
  assign rsp.block_count = count_r;
  assign rsp.used_map    = MAP_W'(u_v[MAPN-1:0]);

endmodule

// File: rtl/cbba_checker.sv
// Port-level checks on the allocator top level, with its bind.
`include "assert_macros.svh"

module cbba_checker
  import cbba_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input cbba_req_t req,
  input logic      done,
  input cbba_rsp_t rsp
);

  logic accept;
  logic free_acc;
  logic run_zero;

  assign accept   = start && !busy;
  assign free_acc = accept && (req.opcode == OP_FREE);
  assign run_zero = (rsp.first_block == '0) && (rsp.block_count == '0);

  `CHK_ASSERT(a_done_idle, done |-> !busy, "result strobe while busy")
  `CHK_ASSERT(a_accept_busy, accept |=> busy, "transfer accepted without going busy")
  `CHK_ASSERT(a_fail_zero, (done && !rsp.ok) |-> run_zero, "failed result carries a run")
  `CHK_ASSERT(a_free_lat, free_acc |=> ##1 (done && rsp.ok), "free result late or failed")
  `CHK_ASSERT_ALWAYS(a_rst_quiet, rst |=> !done, "result strobe after reset")

endmodule

bind contiguous_block_bitmap_allocator_top cbba_checker u_cbba_checker (.*);
